@@ hdl/group_varint_encoder_core_defines.svh @@
// Assertion macros for the group varint encoder checker.
// Needs clk_i and rst_ni in scope where a macro is used.
`ifndef GROUP_VARINT_ENCODER_CORE_DEFINES_SVH
`define GROUP_VARINT_ENCODER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GVE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GVE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gve_pkg.sv @@
// Shared types, constants and functions of the group varint encoder.
// Used by the front end, the command queue, the byte emitter and the top level.
package gve_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam logic [7:0] Sentinel = 8'hF0;

  // One emission command: a header byte followed by one or two little-endian
  // words, each sent as len + 1 bytes.
  typedef struct packed {
    logic [7:0]  hdr;
    logic [31:0] w0;
    logic [1:0]  len0;
    logic [31:0] w1;
    logic [1:0]  len1;
    logic        has1;
    logic        last;
    logic        send;
  } cmd_t;

  function automatic logic [1:0] size_code(input logic [31:0] v);
    logic [1:0] c;
    if (v[31:8] == 24'd0) begin
      c = 2'd0;
    end else if (v[31:16] == 16'd0) begin
      c = 2'd1;
    end else if (v[31:24] == 8'd0) begin
      c = 2'd2;
    end else begin
      c = 2'd3;
    end
    return c;
  endfunction

endpackage

@@ hdl/gve_front.sv @@
// Front end: accepts values, keeps the four-entry window and turns it into
// emission commands. Depends on gve_pkg.
module gve_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   in_value_i,
  input  logic          in_final_i,
  output logic          push_o,
  output gve_pkg::cmd_t cmd_o,
  input  logic          full_i
);
  import gve_pkg::*;

  typedef enum logic {ST_IDLE, ST_WORK} state_e;

  state_e      state_q;
  logic [31:0] win_q [4];
  logic [2:0]  cnt_q;
  logic [2:0]  cnt_d;
  logic        fin_q;
  logic        four;
  logic        all_narrow;
  logic        n2;
  logic        do_cmd;
  logic [1:0]  c0;
  logic [1:0]  c1;
  cmd_t        cmd;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    four       = (cnt_q == 3'd4);
    all_narrow = (win_q[0][31:8] == 24'd0) && (win_q[1][31:8] == 24'd0) &&
                 (win_q[2][31:8] == 24'd0) && (win_q[3][31:8] == 24'd0);
    n2         = four || (cnt_q >= 3'd2);
    do_cmd     = four || (fin_q && (cnt_q != 3'd0));
    c0         = size_code(win_q[0]);
    c1         = size_code(win_q[1]);
    if (four && all_narrow) begin
      cmd.hdr  = Sentinel;
      cmd.w0   = {win_q[3][7:0], win_q[2][7:0], win_q[1][7:0], win_q[0][7:0]};
      cmd.len0 = 2'd3;
      cmd.w1   = win_q[1];
      cmd.len1 = 2'd0;
      cmd.has1 = 1'b0;
      cnt_d    = 3'd0;
    end else begin
      cmd.hdr  = {2'b00, (n2 ? c1 : 2'b00), 2'b00, c0};
      cmd.w0   = win_q[0];
      cmd.len0 = c0;
      cmd.w1   = win_q[1];
      cmd.len1 = c1;
      cmd.has1 = n2;
      cnt_d    = n2 ? cnt_q - 3'd2 : cnt_q - 3'd1;
    end
    cmd.last = !(fin_q && (cnt_d != 3'd0));
    cmd.send = cmd.last && fin_q;
  end

  assign cmd_o  = cmd;
  assign push_o = (state_q == ST_WORK) && do_cmd && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
      fin_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= cnt_q + 3'd1;
            fin_q   <= in_final_i;
            state_q <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (!do_cmd) begin
            state_q <= ST_IDLE;
          end else if (!full_i) begin
            cnt_q <= cnt_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      win_q[cnt_q[1:0]] <= in_value_i;
    end else if (push_o && n2) begin
      win_q[0] <= win_q[2];
      win_q[1] <= win_q[3];
    end
  end

endmodule

@@ hdl/gve_queue.sv @@
// Short command queue between the front end and the byte emitter.
// Depends on gve_pkg for the command type.
module gve_queue #(
  parameter int unsigned Depth = gve_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gve_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output gve_pkg::cmd_t data_o,
  output logic          empty_o
);
  import gve_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hdl/gve_emit.sv @@
// Byte emitter: walks one command at a time and drives the registered
// byte output. Depends on gve_pkg.
module gve_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  gve_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_end_o
);
  import gve_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_DAT0, PH_DAT1} phase_e;

  phase_e     phase_q;
  cmd_t       cmd_q;
  logic [1:0] idx_q;
  logic       load;
  logic       fin;
  logic [7:0] byte_d;

  assign load = !out_valid_o || out_ready_i;

  always_comb begin
    fin    = 1'b0;
    byte_d = cmd_q.hdr;
    case (phase_q)
      PH_HDR:  byte_d = cmd_q.hdr;
      PH_DAT0: begin
        byte_d = cmd_q.w0[8*idx_q +: 8];
        fin    = (idx_q == cmd_q.len0) && !cmd_q.has1;
      end
      PH_DAT1: begin
        byte_d = cmd_q.w1[8*idx_q +: 8];
        fin    = (idx_q == cmd_q.len1);
      end
      default: byte_d = cmd_q.hdr;
    endcase
  end

  assign pop_o = load && !empty_i && ((phase_q == PH_IDLE) || fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      idx_q       <= 2'd0;
      out_valid_o <= 1'b0;
      out_last_o  <= 1'b0;
      out_end_o   <= 1'b0;
    end else if (load) begin
      out_valid_o <= (phase_q != PH_IDLE);
      out_last_o  <= fin && cmd_q.last;
      out_end_o   <= fin && cmd_q.send;
      case (phase_q)
        PH_IDLE: begin
          if (!empty_i) begin
            phase_q <= PH_HDR;
          end
        end
        PH_HDR: begin
          phase_q <= PH_DAT0;
          idx_q   <= 2'd0;
        end
        PH_DAT0: begin
          if (idx_q == cmd_q.len0) begin
            idx_q <= 2'd0;
            if (cmd_q.has1) begin
              phase_q <= PH_DAT1;
            end else begin
              phase_q <= empty_i ? PH_IDLE : PH_HDR;
            end
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        PH_DAT1: begin
          if (idx_q == cmd_q.len1) begin
            idx_q   <= 2'd0;
            phase_q <= empty_i ? PH_IDLE : PH_HDR;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o <= byte_d;
    end
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

endmodule

@@ hdl/group_varint_encoder_core.sv @@
// Group varint encoder top level: front end, command queue and byte emitter.
// Depends on gve_pkg, gve_front, gve_queue and gve_emit.
//
// Input channel s_axis: one 32-bit value per transfer in tdata; tlast marks
// the value that ends the array and flushes the window. Output channel
// m_axis: one encoded byte per transfer in tdata (sentinel, header or data),
// tlast on the last byte caused by an input value, tuser on the last byte of
// the whole array. An input value that only fills the window causes no byte.
// The front end takes one value, then builds up to two commands from the
// window, one at a time, and goes back to idle before it takes the next
// value; a full queue holds it. The emitter sends one byte per cycle while
// the receiver takes each byte; the byte rate of the output port sets the
// sustained throughput. A transfer's first byte passes through the window,
// the queue and the emitter's command register. When the receiver stalls, the
// output byte holds, the queue fills and the front end stops taking values.
// Reset empties the window, the queue and the output register.
module group_varint_encoder_core #(
  parameter int unsigned QueueDepth = gve_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value [31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // stream_end [0]
);
  import gve_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  gve_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full)
  );

  gve_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  gve_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_end_o   (m_axis_tuser)
  );

endmodule

@@ hdl/gve_checker.sv @@
// Port-level checker for the group varint encoder, bound to the top level.
// Depends on group_varint_encoder_core_defines.svh.
`include "group_varint_encoder_core_defines.svh"

module gve_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  `GVE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "Output transfer dropped while stalled.")
  `GVE_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "Output byte changed while stalled.")
  `GVE_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "End of array without end of run.")
  `GVE_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "Front end took a second value while busy.")

endmodule

bind group_varint_encoder_core gve_checker u_checker (.*);
